FILE: hw/rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg: shared constants, types and functions of the integer formatter
// Holds the datapath sizes, mode codes, ASCII codes and the queue entry type.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // Widest operand that the datapath holds (8 to 64).
  localparam int ValueBits  = 64;
  // Effective width when the narrow operand width is selected.
  localparam int NarrowBits = (ValueBits < 32) ? ValueBits : 32;
  // Digit counts needed for the largest magnitude in each base.
  localparam int HexDigits  = (ValueBits + 3) / 4;
  localparam int DecDigits  = (ValueBits * 1233) / 4096 + 1;
  localparam int DigW       = DecDigits * 4;
  localparam int HexW       = HexDigits * 4;
  localparam int BitCntW    = $clog2(ValueBits + 1);
  localparam int DigCntW    = $clog2(DecDigits + 1);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Mode codes; bit 1 of the mode selects hexadecimal.
  localparam logic [1:0] ModeUdec   = 2'd0;
  localparam logic [1:0] ModeSdec   = 2'd1;
  localparam logic [1:0] ModeHex    = 2'd2;
  localparam int         ModeHexBit = 1;

  localparam logic [6:0] CharMinus  = 7'h2d;
  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharLowerA = 7'h61;

  // One classified operand, as handed from the front end to the back end.
  typedef struct packed {
    logic                 neg;
    logic                 hex;
    logic [ValueBits-1:0] mag;
  } item_t;

  // Maps a digit value to its lowercase ASCII character.
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CharZero + {3'b000, d};
    end else begin
      c = CharLowerA + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/itaf_if.sv
// ----------------------------------------------------------------------------
// itaf_if: valid/ready channels of the integer formatter
// Operand channel into the block and character channel out of it.
// ----------------------------------------------------------------------------
interface itaf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        operand_width;
  logic [63:0] operand_value;

  modport source (output valid, mode, operand_width, operand_value, input ready);
  modport sink   (input valid, mode, operand_width, operand_value, output ready);
endinterface

interface itaf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

FILE: hw/rtl/itaf_front.sv
// ----------------------------------------------------------------------------
// itaf_front: operand intake and classification
// Cuts the operand to its width, extends it, and forms sign and magnitude.
// ----------------------------------------------------------------------------
module itaf_front (
  itaf_in_if.sink            in_i,
  input  logic               full_i,
  output logic               push_o,
  output itaf_pkg::item_t    item_o
);

  logic [itaf_pkg::ValueBits-1:0] raw;
  logic [itaf_pkg::ValueBits-1:0] keep_mask;
  logic [itaf_pkg::ValueBits-1:0] kept;
  logic [itaf_pkg::ValueBits-1:0] ext;
  logic                           sign_bit;
  logic                           neg;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    raw = in_i.operand_value[itaf_pkg::ValueBits-1:0];
    for (int i = 0; i < itaf_pkg::ValueBits; i++) begin
      keep_mask[i] = in_i.operand_width || (i < itaf_pkg::NarrowBits);
    end
    kept     = raw & keep_mask;
    sign_bit = in_i.operand_width ? raw[itaf_pkg::ValueBits-1]
                                  : raw[itaf_pkg::NarrowBits-1];
    neg      = (in_i.mode == itaf_pkg::ModeSdec) && sign_bit;
    // Sign extension fills the bits above the selected width.
    ext      = neg ? (kept | ~keep_mask) : kept;
    item_o.neg = neg;
    item_o.hex = in_i.mode[itaf_pkg::ModeHexBit];
    // Unsigned negation keeps the most negative value exact.
    item_o.mag = neg ? (~ext + itaf_pkg::ValueBits'(1)) : ext;
  end

endmodule

FILE: hw/rtl/itaf_queue.sv
// ----------------------------------------------------------------------------
// itaf_queue: short queue between front end and back end
// Holds classified operands so that intake and conversion stall separately.
// ----------------------------------------------------------------------------
module itaf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  itaf_pkg::item_t    item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output itaf_pkg::item_t    item_o
);

  itaf_pkg::item_t                mem_q [itaf_pkg::QueueDepth];
  logic [itaf_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [itaf_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [itaf_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = (cnt_q == itaf_pkg::QCntW'(itaf_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == itaf_pkg::QPtrW'(itaf_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == itaf_pkg::QPtrW'(itaf_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // The fill count never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= itaf_pkg::QCntW'(itaf_pkg::QueueDepth))
    else $error("queue count above depth");

endmodule

FILE: hw/rtl/itaf_back.sv
// ----------------------------------------------------------------------------
// itaf_back: digit conversion and character emission
// Bit-serial binary to BCD conversion, leading zero skip, character output.
// ----------------------------------------------------------------------------
module itaf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  itaf_pkg::item_t    item_i,
  output logic               pop_o,
  itaf_out_if.source         out_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic [itaf_pkg::BitCntW-1:0]     bitcnt_q, bitcnt_d;
  logic [itaf_pkg::DigCntW-1:0]     dcnt_q, dcnt_d;
  logic                             neg_q, neg_d;
  logic                             out_valid_q, out_valid_d;
  logic [itaf_pkg::ValueBits-1:0]   bin_q, bin_d;
  logic [itaf_pkg::DigW-1:0]        dig_q, dig_d;
  logic [6:0]                       char_q, char_d;
  logic                             last_q, last_d;
  logic [itaf_pkg::DigW-1:0]        dig_adj;
  logic [itaf_pkg::HexW-1:0]        hex_val;
  logic [3:0]                       top_dig;
  logic                             out_free;

  assign top_dig   = dig_q[itaf_pkg::DigW-1 -: 4];
  assign out_free  = !out_valid_q || out_o.ready;
  assign hex_val   = itaf_pkg::HexW'(item_i.mag);

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

  // Add-3 correction on every BCD digit of five or more before each shift.
  always_comb begin
    for (int j = 0; j < itaf_pkg::DecDigits; j++) begin
      dig_adj[4*j +: 4] = (dig_q[4*j +: 4] >= 4'd5) ? dig_q[4*j +: 4] + 4'd3
                                                   : dig_q[4*j +: 4];
    end
  end

  always_comb begin
    state_d     = state_q;
    bitcnt_d    = bitcnt_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    bin_d       = bin_q;
    dig_d       = dig_q;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      StIdle: begin
        if (valid_i) begin
          pop_o = 1'b1;
          neg_d = item_i.neg;
          if (item_i.hex) begin
            dig_d   = itaf_pkg::DigW'(hex_val)
                      << ((itaf_pkg::DecDigits - itaf_pkg::HexDigits) * 4);
            dcnt_d  = itaf_pkg::DigCntW'(itaf_pkg::HexDigits);
            state_d = StSkip;
          end else begin
            bin_d    = item_i.mag;
            dig_d    = '0;
            bitcnt_d = itaf_pkg::BitCntW'(itaf_pkg::ValueBits);
            dcnt_d   = itaf_pkg::DigCntW'(itaf_pkg::DecDigits);
            state_d  = StConv;
          end
        end
      end
      StConv: begin
        dig_d    = {dig_adj[itaf_pkg::DigW-2:0], bin_q[itaf_pkg::ValueBits-1]};
        bin_d    = bin_q << 1;
        bitcnt_d = bitcnt_q - 1'b1;
        if (bitcnt_q == itaf_pkg::BitCntW'(1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_dig == 4'd0 && dcnt_q > itaf_pkg::DigCntW'(1)) begin
          dig_d  = dig_q << 4;
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itaf_pkg::CharMinus;
          last_d      = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itaf_pkg::digit_char(top_dig);
          last_d      = (dcnt_q == itaf_pkg::DigCntW'(1));
          dig_d       = dig_q << 4;
          dcnt_d      = dcnt_q - 1'b1;
          if (dcnt_q == itaf_pkg::DigCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      bitcnt_q    <= '0;
      dcnt_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bitcnt_q    <= bitcnt_d;
      dcnt_q      <= dcnt_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Emission never starts with an exhausted digit count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit || state_q == StSign) |-> dcnt_q != '0)
    else $error("emission with no digits left");

  // The conversion loop always has bits left to shift.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StConv |-> bitcnt_q != '0)
    else $error("conversion with no bits left");

  // A new character only appears from the sign or digit states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StSign || $past(state_q) == StEmit))
    else $error("character produced outside emission");

endmodule

FILE: hw/rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: integer to ASCII text formatter
// Prints one operand as unsigned decimal, signed decimal or lowercase hex text.
// ----------------------------------------------------------------------------
// Sequence: a word is registered in the queue, then a decimal word is loaded,
//   runs through the conversion loop and skips its leading zero digits.
// A hex word skips the conversion loop: it is loaded and skips leading zeros.
// A sign character goes before a negative number, then the characters follow,
//   one per cycle while the receiver is ready; a two-entry queue takes the next
//   operands meanwhile.
// Reset (rst_ni, asynchronous, active low) empties the queue and the output.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  itaf_in_if.sink    in_i,
  itaf_out_if.source out_o
);

  // The front end classifies each operand word in the cycle it arrives:
  // width cut, sign or zero extension, sign flag and unsigned magnitude.
  // Those results wait in a short queue so that intake waits on the long
  // conversion of the word ahead of it only when the queue is full.
  itaf_pkg::item_t front_item;
  itaf_pkg::item_t queue_item;
  logic            push;
  logic            full;
  logic            queue_valid;
  logic            pop;

  itaf_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  itaf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .item_o  (queue_item)
  );

  // The back end converts the magnitude with a shift-and-add-3 loop (or
  // loads hex nibbles directly), drops leading zeros while keeping at least
  // one digit, and hands out one character word at a time through an output
  // register, with the last character of each number flagged.
  itaf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .item_i  (queue_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
